>>> design/edt_pkg.sv
`timescale 1ns / 1ps
// Package of the encounter deduplication table: field widths, register
// indexes, status codes and the configuration struct. Depends on nothing.
package edt_pkg;

	// Field widths.
	localparam int ID_W    = 32;
	localparam int DIST_W  = 8;
	localparam int CNT_W   = 16;
	localparam int PEND_W  = 8;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 2;
	localparam int CDATA_W = 32;

	// Default depth of the table of recently seen identifiers.
	localparam int TABLE_DEPTH_DEF = 32;

	// Distance that means not connected, and the reset batch size.
	localparam logic [DIST_W-1:0] DIST_NONE   = 8'hFF;
	localparam logic [PEND_W-1:0] BATCH_RESET = 8'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] STATUS_NEW  = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_OWN  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_SEEN = 2'd2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_OWN_ID        = 2'd0;
	localparam logic [IDX_W-1:0] REG_FLUSH_ENABLED = 2'd1;
	localparam logic [IDX_W-1:0] REG_FLUSH_BATCH   = 2'd2;

	// Current register contents.
	typedef struct packed {
		logic [ID_W-1:0]   own_id;
		logic              flush_enabled;
		logic [PEND_W-1:0] flush_batch;
	} cfg_t;

endpackage

>>> design/edt_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the encounter deduplication table: input words,
// result words and configuration writes. Depends on edt_pkg.

// Input channel: one encounter per word.
interface edt_in_if;
	logic                       valid;
	logic                       ready;
	logic [edt_pkg::ID_W-1:0]   peer_id;
	logic [edt_pkg::DIST_W-1:0] peer_distance;

	modport source (output valid, output peer_id, output peer_distance, input ready);
	modport sink (input valid, input peer_id, input peer_distance, output ready);
endinterface

// Result channel: one result word per input word.
interface edt_out_if;
	logic                       valid;
	logic                       ready;
	logic [edt_pkg::STAT_W-1:0] status;
	logic [edt_pkg::CNT_W-1:0]  encounter_total;
	logic [edt_pkg::DIST_W-1:0] hop_distance;
	logic                       flush_request;

	modport source (output valid, output status, output encounter_total,
		output hop_distance, output flush_request, input ready);
	modport sink (input valid, input status, input encounter_total,
		input hop_distance, input flush_request, output ready);
endinterface

// Configuration write channel.
interface edt_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [edt_pkg::IDX_W-1:0]   index;
	logic [edt_pkg::CDATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/edt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module edt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/edt_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the encounter deduplication table, written over
// the configuration channel. Depends on edt_pkg and edt_if.
module edt_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	edt_cfg_if.sink       cfg,
	output edt_pkg::cfg_t regs
);

	edt_pkg::cfg_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register decode; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.own_id        <= '0;
			regs_q.flush_enabled <= 1'b0;
			regs_q.flush_batch   <= edt_pkg::BATCH_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				edt_pkg::REG_OWN_ID: begin
					regs_q.own_id <= cfg.data[edt_pkg::ID_W-1:0];
				end
				edt_pkg::REG_FLUSH_ENABLED: begin
					regs_q.flush_enabled <= cfg.data[0];
				end
				edt_pkg::REG_FLUSH_BATCH: begin
					regs_q.flush_batch <= cfg.data[edt_pkg::PEND_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> design/encounter_dedup_table_core.sv
// An accepted identifier is compared with the identifiers held in the table,
// and the search stops on a match. An own reflection or an empty table skips
// the search. The search reads one table entry per cycle from the RAM.
// The result then waits in the done state until the output register is free.
// Items are handled one at a time: a new one is taken only in the idle state.
// Reset clears the counters, fill level and distance at once; the table RAM
// needs no clearing because only entries below the fill level are read.
`timescale 1ns / 1ps
// Top level of the encounter deduplication table: sequencer, search over the
// table RAM and state update. Depends on edt_pkg, edt_if, edt_ram, edt_cfg_regs.
module encounter_dedup_table_core #(
	parameter int TABLE_DEPTH = edt_pkg::TABLE_DEPTH_DEF
) (
	input logic     clk,
	input logic     arst_n,
	edt_in_if.sink  item,
	edt_out_if.source result,
	edt_cfg_if.sink cfg
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(TABLE_DEPTH);
	localparam logic [AW-1:0] HEAD_LAST = AW'(TABLE_DEPTH - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	edt_pkg::cfg_t regs;

	logic [1:0]                 state_q;
	logic [edt_pkg::ID_W-1:0]   id_q;
	logic [edt_pkg::DIST_W-1:0] dist_q;
	logic [edt_pkg::STAT_W-1:0] status_q;
	logic [FW-1:0]              fill_q;
	logic [AW-1:0]              head_q;
	logic [FW-1:0]              rd_cnt_q;
	logic                       cmp_valid_s1;
	logic                       cmp_last_s1;
	logic [edt_pkg::CNT_W-1:0]  count_q;
	logic [edt_pkg::DIST_W-1:0] own_dist_q;
	logic [edt_pkg::PEND_W-1:0] pending_q;

	logic                       out_valid_q;
	logic [edt_pkg::STAT_W-1:0] out_status_q;
	logic [edt_pkg::CNT_W-1:0]  out_total_q;
	logic [edt_pkg::DIST_W-1:0] out_dist_q;
	logic                       out_flush_q;

	logic                       accept;
	logic                       issue;
	logic                       hit;
	logic                       full;
	logic                       out_load;
	logic                       commit;
	logic [edt_pkg::ID_W-1:0]   rdata;
	logic [AW-1:0]              waddr;
	logic [edt_pkg::DIST_W:0]   cand;
	logic [edt_pkg::CNT_W-1:0]  count_nx;
	logic [edt_pkg::DIST_W-1:0] dist_nx;
	logic [edt_pkg::PEND_W-1:0] pend_inc;
	logic [edt_pkg::PEND_W-1:0] pend_nx;
	logic                       flush_nx;

	// Configuration registers.
	edt_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Table of recently seen identifiers, kept as a ring once full.
	edt_ram #(
		.WIDTH (edt_pkg::ID_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (commit),
		.waddr (waddr),
		.wdata (id_q),
		.re    (issue),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (rdata)
	);

	// Handshake and search control. Writes happen only in the done state and
	// reads only in the search state, so the two never meet on one entry.
	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign issue      = (state_q == ST_SEARCH) && (rd_cnt_q < fill_q);
	assign hit        = cmp_valid_s1 && (rdata == id_q);
	assign full       = (fill_q == FILL_FULL);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	assign commit     = out_load && (status_q == edt_pkg::STATUS_NEW);
	assign waddr      = full ? head_q : fill_q[AW-1:0];

	// State update for a new encounter.
	always_comb begin
		count_nx = count_q + edt_pkg::CNT_W'(1);
		cand     = {1'b0, dist_q} + (edt_pkg::DIST_W + 1)'(1);
		dist_nx  = own_dist_q;
		if (dist_q != edt_pkg::DIST_NONE && cand < {1'b0, own_dist_q}) begin
			dist_nx = cand[edt_pkg::DIST_W-1:0];
		end
		pend_inc = pending_q + edt_pkg::PEND_W'(1);
		pend_nx  = pend_inc;
		flush_nx = 1'b0;
		if (regs.flush_enabled && pend_inc >= regs.flush_batch) begin
			pend_nx  = '0;
			flush_nx = 1'b1;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_cnt_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			cmp_last_s1  <= 1'b0;
			status_q     <= edt_pkg::STATUS_NEW;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_cnt_q     <= '0;
					cmp_valid_s1 <= 1'b0;
					cmp_last_s1  <= 1'b0;
					if (accept) begin
						if (item.peer_id == regs.own_id) begin
							status_q <= edt_pkg::STATUS_OWN;
							state_q  <= ST_DONE;
						end else if (fill_q == '0) begin
							status_q <= edt_pkg::STATUS_NEW;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					cmp_valid_s1 <= issue;
					cmp_last_s1  <= (rd_cnt_q + FW'(1)) == fill_q;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + FW'(1);
					end
					if (hit) begin
						status_q <= edt_pkg::STATUS_SEEN;
						state_q  <= ST_DONE;
					end else if (cmp_valid_s1 && cmp_last_s1) begin
						status_q <= edt_pkg::STATUS_NEW;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured input word.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= item.peer_id;
			dist_q <= item.peer_distance;
		end
	end

	// Encounter state, written back when a new encounter is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			head_q     <= '0;
			count_q    <= '0;
			own_dist_q <= edt_pkg::DIST_NONE;
			pending_q  <= '0;
		end else if (commit) begin
			if (full) begin
				head_q <= (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
			end else begin
				fill_q <= fill_q + FW'(1);
			end
			count_q    <= count_nx;
			own_dist_q <= dist_nx;
			pending_q  <= pend_nx;
		end
	end

	// Output register; the result waits here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			if (commit) begin
				out_total_q <= count_nx;
				out_dist_q  <= dist_nx;
				out_flush_q <= flush_nx;
			end else begin
				out_total_q <= count_q;
				out_dist_q  <= own_dist_q;
				out_flush_q <= 1'b0;
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = out_status_q;
	assign result.encounter_total = out_total_q;
	assign result.hop_distance    = out_dist_q;
	assign result.flush_request   = out_flush_q;

endmodule
